### hw/rtl/psd_pkg.sv
// Package for the program stream demultiplexer: parse phases, queue command
// codes, result record and stream constants. Depends on nothing.
`default_nettype none

package psd_pkg;

  // Default depth of the command queue between parser and unit tracker.
  localparam int unsigned PSD_QUEUE_DEPTH = 4;

  // Start code identifiers and stream code fields.
  localparam logic [7:0] SC_PACK        = 8'hBA;
  localparam logic [7:0] SC_END         = 8'hB9;
  localparam logic [7:0] SC_PRIVATE1    = 8'hBD;
  localparam logic [3:0] SC_VIDEO_NIB   = 4'hE;
  localparam logic [2:0] PACK_STUFF_MSK = 3'h7;
  localparam int unsigned PTS_FLAG_BIT  = 7;
  localparam int unsigned DTS_FLAG_BIT  = 6;

  // Result kinds and stream selectors.
  localparam logic KIND_PAYLOAD  = 1'b0;
  localparam logic KIND_UNIT_END = 1'b1;
  localparam logic SEL_VIDEO     = 1'b0;
  localparam logic SEL_AUDIO     = 1'b1;

  // Input operation codes.
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef enum logic [3:0] {
    PH_SEARCH  = 4'd0,
    PH_ID      = 4'd1,
    PH_PACK    = 4'd2,
    PH_STUFF   = 4'd3,
    PH_LEN_HI  = 4'd4,
    PH_LEN_LO  = 4'd5,
    PH_FLAG1   = 4'd6,
    PH_FLAG2   = 4'd7,
    PH_HLEN    = 4'd8,
    PH_HEADER  = 4'd9,
    PH_PAYLOAD = 4'd10,
    PH_SKIP    = 4'd11
  } psd_phase_e;

  // Commands handed from the parser to the unit tracker.
  typedef enum logic [2:0] {
    CMD_DATA  = 3'd0,
    CMD_CLOSE = 3'd1,
    CMD_PTS   = 3'd2,
    CMD_DTS   = 3'd3,
    CMD_FLUSH = 3'd4
  } psd_cmd_e;

  typedef struct packed {
    psd_cmd_e    op;
    logic        sel;
    logic [32:0] value;
  } psd_cmd_t;

  typedef struct packed {
    logic        kind;
    logic        stream_sel;
    logic [7:0]  out_byte;
    logic        unit_first;
    logic        ts_present;
    logic [32:0] pts_value;
    logic [32:0] dts_value;
  } psd_result_t;

endpackage

`default_nettype wire

### hw/rtl/psd_if.sv
// Valid/ready channel interfaces for the input bytes and the output results.
// No dependencies.
`default_nettype none

interface psd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_byte;

  modport source (output valid, output op, output in_byte, input ready);
  modport sink   (input valid, input op, input in_byte, output ready);
endinterface

interface psd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        stream_sel;
  logic [7:0]  out_byte;
  logic        unit_first;
  logic        ts_present;
  logic [32:0] pts_value;
  logic [32:0] dts_value;

  modport source (output valid, output kind, output stream_sel, output out_byte,
                  output unit_first, output ts_present, output pts_value,
                  output dts_value, input ready);
  modport sink   (input valid, input kind, input stream_sel, input out_byte,
                  input unit_first, input ts_present, input pts_value,
                  input dts_value, output ready);
endinterface

`default_nettype wire

### hw/rtl/psd_parser.sv
// Front end: program stream parser that follows start codes and packet
// headers and issues unit commands. Depends on psd_pkg.
`default_nettype none

module psd_parser
  import psd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_fire_i,
  input  logic       op_i,
  input  logic [7:0] in_byte_i,
  output logic       cmd_push_o,
  output psd_cmd_t   cmd_o
);

  psd_phase_e  phase_q, phase_d;
  logic [23:0] window_q, window_d;
  logic [7:0]  pos_q, pos_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  hlen_q, hlen_d;
  logic [2:0]  stuff_q, stuff_d;
  logic [32:0] pts_q, pts_d;
  logic [32:0] dts_q, dts_d;

  logic [23:0] window_new;
  logic [7:0]  pos_new;
  logic [15:0] len_dec;
  logic [7:0]  hlen_dec;
  logic [8:0]  hdr_full;
  logic        is_video;
  logic        is_target;
  logic        sel;
  logic        pts_field;
  logic        dts_field;
  logic [2:0]  sub_hdr;

  // Classification of the current packet and header byte.
  assign is_video   = (code_q[7:4] == SC_VIDEO_NIB);
  assign is_target  = is_video || (code_q == SC_PRIVATE1);
  assign sel        = is_video ? SEL_VIDEO : SEL_AUDIO;
  assign window_new = {window_q[15:0], in_byte_i};
  assign pos_new    = (pos_q < 8'd3) ? (pos_q + 8'd1) : pos_q;
  assign len_dec    = len_q - 16'd1;
  assign hlen_dec   = hlen_q - 8'd1;
  assign hdr_full   = {1'b0, pos_q} + {1'b0, hlen_q};
  assign pts_field  = flags_q[PTS_FLAG_BIT] && (hdr_full >= 9'd5) && (pos_q < 8'd5);
  assign dts_field  = flags_q[PTS_FLAG_BIT] && flags_q[DTS_FLAG_BIT] &&
                      (hdr_full >= 9'd10) && (pos_q >= 8'd5) && (pos_q < 8'd10);
  assign sub_hdr    = ((code_q == SC_PRIVATE1) && (len_dec >= 16'd4)) ? 3'd4 : 3'd0;

  // Next parse state and command for one accepted item.
  always_comb begin
    phase_d    = phase_q;
    window_d   = window_q;
    pos_d      = pos_q;
    len_d      = len_q;
    code_d     = code_q;
    flags_d    = flags_q;
    hlen_d     = hlen_q;
    stuff_d    = stuff_q;
    pts_d      = pts_q;
    dts_d      = dts_q;
    cmd_push_o = 1'b0;
    cmd_o      = '{op: CMD_DATA, sel: sel, value: {25'd0, in_byte_i}};

    if (item_fire_i && (op_i == OP_FLUSH)) begin
      cmd_push_o = 1'b1;
      cmd_o.op   = CMD_FLUSH;
    end else if (item_fire_i) begin
      case (phase_q)
        PH_ID: begin
          code_d = in_byte_i;
          if (in_byte_i == SC_PACK) begin
            pos_d   = 8'd4;
            phase_d = PH_PACK;
          end else if (in_byte_i == SC_END) begin
            phase_d  = PH_SEARCH;
            window_d = '0;
            pos_d    = '0;
          end else begin
            phase_d = PH_LEN_HI;
          end
        end
        PH_PACK: begin
          if (pos_q >= 8'd13) begin
            stuff_d = in_byte_i[2:0] & PACK_STUFF_MSK;
            if (stuff_d == 3'd0) begin
              phase_d  = PH_SEARCH;
              window_d = '0;
              pos_d    = '0;
            end else begin
              phase_d = PH_STUFF;
            end
          end else begin
            pos_d = pos_q + 8'd1;
          end
        end
        PH_STUFF: begin
          stuff_d = stuff_q - 3'd1;
          if (stuff_d == 3'd0) begin
            phase_d  = PH_SEARCH;
            window_d = '0;
            pos_d    = '0;
          end
        end
        PH_LEN_HI: begin
          len_d   = {in_byte_i, 8'd0};
          phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_d = {len_q[15:8], in_byte_i};
          if (is_target && (len_d >= 16'd3)) begin
            phase_d = PH_FLAG1;
          end else if (len_d == 16'd0) begin
            phase_d  = PH_SEARCH;
            window_d = '0;
            pos_d    = '0;
          end else begin
            phase_d = PH_SKIP;
          end
        end
        PH_SKIP: begin
          len_d = len_dec;
          if (len_dec == 16'd0) begin
            phase_d  = PH_SEARCH;
            window_d = '0;
            pos_d    = '0;
          end
        end
        PH_FLAG1: begin
          len_d   = len_dec;
          phase_d = PH_FLAG2;
        end
        PH_FLAG2: begin
          flags_d = in_byte_i;
          len_d   = len_dec;
          phase_d = PH_HLEN;
        end
        PH_HLEN: begin
          len_d  = len_dec;
          hlen_d = in_byte_i;
          if ({8'd0, in_byte_i} > len_dec) begin
            // Header longer than the packet: skip the rest, no unit change.
            if (len_dec == 16'd0) begin
              phase_d  = PH_SEARCH;
              window_d = '0;
              pos_d    = '0;
            end else begin
              phase_d = PH_SKIP;
            end
          end else begin
            if (flags_q[PTS_FLAG_BIT]) begin
              cmd_push_o = 1'b1;
              cmd_o.op   = CMD_CLOSE;
            end
            pos_d = '0;
            pts_d = '0;
            dts_d = '0;
            if (in_byte_i != 8'd0) begin
              phase_d = PH_HEADER;
            end else if (len_dec == 16'd0) begin
              phase_d  = PH_SEARCH;
              window_d = '0;
              pos_d    = '0;
            end else begin
              phase_d = PH_PAYLOAD;
              stuff_d = sub_hdr;
            end
          end
        end
        PH_HEADER: begin
          len_d  = len_dec;
          hlen_d = hlen_dec;
          pos_d  = pos_q + 8'd1;
          // Timestamp fields are gathered three, seven or eight bits a byte.
          if (pts_field) begin
            case (pos_q[2:0])
              3'd0: pts_d = {in_byte_i[3:1], 30'd0};
              3'd1: pts_d = pts_q | {3'd0, in_byte_i, 22'd0};
              3'd2: pts_d = pts_q | {11'd0, in_byte_i[7:1], 15'd0};
              3'd3: pts_d = pts_q | {18'd0, in_byte_i, 7'd0};
              default: begin
                pts_d      = pts_q | {26'd0, in_byte_i[7:1]};
                cmd_push_o = 1'b1;
                cmd_o.op   = CMD_PTS;
                cmd_o.value = pts_d;
              end
            endcase
          end
          if (dts_field) begin
            case (pos_q)
              8'd5: dts_d = {in_byte_i[3:1], 30'd0};
              8'd6: dts_d = dts_q | {3'd0, in_byte_i, 22'd0};
              8'd7: dts_d = dts_q | {11'd0, in_byte_i[7:1], 15'd0};
              8'd8: dts_d = dts_q | {18'd0, in_byte_i, 7'd0};
              default: begin
                dts_d      = dts_q | {26'd0, in_byte_i[7:1]};
                cmd_push_o = 1'b1;
                cmd_o.op   = CMD_DTS;
                cmd_o.value = dts_d;
              end
            endcase
          end
          if (hlen_dec == 8'd0) begin
            if (len_dec == 16'd0) begin
              phase_d  = PH_SEARCH;
              window_d = '0;
              pos_d    = '0;
            end else begin
              phase_d = PH_PAYLOAD;
              stuff_d = sub_hdr;
            end
          end
        end
        PH_PAYLOAD: begin
          len_d = len_dec;
          if (stuff_q != 3'd0) begin
            // Audio sub-header bytes are dropped.
            stuff_d = stuff_q - 3'd1;
          end else begin
            cmd_push_o = 1'b1;
          end
          if (len_dec == 16'd0) begin
            phase_d  = PH_SEARCH;
            window_d = '0;
            pos_d    = '0;
          end
        end
        default: begin
          // Start code search over the last three bytes.
          phase_d  = PH_SEARCH;
          window_d = window_new;
          pos_d    = pos_new;
          if ((pos_new >= 8'd3) && (window_new == 24'h000001)) begin
            phase_d  = PH_ID;
            window_d = '0;
            pos_d    = '0;
          end
        end
      endcase
    end
  end

  // Parse state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SEARCH;
      window_q <= '0;
      pos_q    <= '0;
      len_q    <= '0;
      code_q   <= '0;
      flags_q  <= '0;
      hlen_q   <= '0;
      stuff_q  <= '0;
      pts_q    <= '0;
      dts_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      window_q <= window_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      code_q   <= code_d;
      flags_q  <= flags_d;
      hlen_q   <= hlen_d;
      stuff_q  <= stuff_d;
      pts_q    <= pts_d;
      dts_q    <= dts_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/psd_cmd_queue.sv
// Short first-in first-out queue of parser commands between the front end
// and the unit tracker. Depends on psd_pkg.
`default_nettype none

module psd_cmd_queue
  import psd_pkg::*;
#(
  parameter int unsigned Depth = PSD_QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  psd_cmd_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     head_valid_o,
  output psd_cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  psd_cmd_t            entry_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push;
  logic                do_pop;

  assign full_o       = (count_q == FullCnt);
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : (wr_ptr_q + PtrW'(1));
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : (rd_ptr_q + PtrW'(1));
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage, written at the tail.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/psd_unit_tracker.sv
// Back end: keeps per-stream access unit state, executes queued commands and
// drives the registered result. Depends on psd_pkg.
`default_nettype none

module psd_unit_tracker
  import psd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  psd_cmd_t    head_i,
  output logic        pop_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output psd_result_t out_o
);

  logic        nonempty_q [2];
  logic        nonempty_d [2];
  logic        has_ts_q [2];
  logic        has_ts_d [2];
  logic [32:0] pts_q [2];
  logic [32:0] pts_d [2];
  logic [32:0] dts_q [2];
  logic [32:0] dts_d [2];
  logic        flush_step_q, flush_step_d;
  logic        out_valid_q;
  psd_result_t out_q;

  logic        out_free;
  logic        fire;
  logic        idx;
  logic        emit;
  psd_result_t res;

  assign out_free = !out_valid_q || out_ready_i;
  assign fire     = head_valid_i && out_free;
  // A flush closes video first, then audio.
  assign idx      = (head_i.op == CMD_FLUSH) ? flush_step_q : head_i.sel;

  // Command execution against the unit state.
  always_comb begin
    nonempty_d   = nonempty_q;
    has_ts_d     = has_ts_q;
    pts_d        = pts_q;
    dts_d        = dts_q;
    flush_step_d = flush_step_q;
    pop_o        = 1'b0;
    emit         = 1'b0;
    res          = '0;
    res.stream_sel = idx;

    if (fire) begin
      case (head_i.op)
        CMD_DATA: begin
          emit         = 1'b1;
          pop_o        = 1'b1;
          res.kind     = KIND_PAYLOAD;
          res.out_byte = head_i.value[7:0];
          if (!nonempty_q[idx]) begin
            res.unit_first = 1'b1;
            res.ts_present = has_ts_q[idx];
            res.pts_value  = pts_q[idx];
            res.dts_value  = dts_q[idx];
          end
          nonempty_d[idx] = 1'b1;
        end
        CMD_PTS: begin
          pop_o         = 1'b1;
          has_ts_d[idx] = 1'b1;
          pts_d[idx]    = head_i.value;
          dts_d[idx]    = head_i.value;
        end
        CMD_DTS: begin
          pop_o      = 1'b1;
          dts_d[idx] = head_i.value;
        end
        CMD_CLOSE, CMD_FLUSH: begin
          // Close the unit; an end is reported only if it held data.
          emit            = nonempty_q[idx];
          res.kind        = KIND_UNIT_END;
          nonempty_d[idx] = 1'b0;
          has_ts_d[idx]   = 1'b0;
          pts_d[idx]      = '0;
          dts_d[idx]      = '0;
          if (head_i.op == CMD_FLUSH) begin
            flush_step_d = !flush_step_q;
            pop_o        = flush_step_q;
          end else begin
            pop_o = 1'b1;
          end
        end
        default: begin
          pop_o = 1'b1;
        end
      endcase
    end
  end

  // Unit state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 2; s++) begin
        nonempty_q[s] <= 1'b0;
        has_ts_q[s]   <= 1'b0;
        pts_q[s]      <= '0;
        dts_q[s]      <= '0;
      end
      flush_step_q <= 1'b0;
    end else begin
      nonempty_q   <= nonempty_d;
      has_ts_q     <= has_ts_d;
      pts_q        <= pts_d;
      dts_q        <= dts_d;
      flush_step_q <= flush_step_d;
    end
  end

  // Output register: loads whenever the previous result leaves or is absent.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

### hw/rtl/program_stream_demultiplexer.sv
// Program stream demultiplexer: one byte or flush transaction in, payload
// bytes and access unit ends out. Top level: parser, command queue, tracker. Depends on
// psd_pkg, psd_if, psd_parser, psd_cmd_queue and psd_unit_tracker.
//
// Usage:
//   in_i carries transactions of op and in_byte; op low is a stream byte,
//   op high a flush that closes the open video and audio access units.
//   out_o carries results: a payload byte of the video or audio elementary
//   stream (with the unit's timestamps on its first byte) or a unit end.
// Path: a result passes through the command queue and then the output register
//   before it appears on out_o, and waits longer while earlier commands sit in the queue.
// Throughput: one byte per cycle; the parser accepts a byte in every cycle
//   while the command queue (QueueDepth entries) has room. A flush is executed
//   by the unit tracker once per elementary stream, video first, then audio.
// Reset: parser returns to start code search, all units are closed and
//   empty, the queue and the output register are emptied.
// Stall: while out_o is not ready the result is held in the output register;
//   the queue keeps accepting until full, then in_i.ready drops.
`default_nettype none

module program_stream_demultiplexer
  import psd_pkg::*;
#(
  parameter int unsigned QueueDepth = PSD_QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  psd_in_if.sink    in_i,
  psd_out_if.source out_o
);

  logic        q_full;
  logic        item_fire;
  logic        cmd_push;
  psd_cmd_t    cmd;
  logic        head_valid;
  psd_cmd_t    head;
  logic        pop;
  psd_result_t res;

  // Input is taken while the queue has room.
  assign in_i.ready = !q_full;
  assign item_fire  = in_i.valid && !q_full;

  psd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_fire_i (item_fire),
    .op_i        (in_i.op),
    .in_byte_i   (in_i.in_byte),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd)
  );

  psd_cmd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (cmd_push),
    .push_data_i  (cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  psd_unit_tracker u_tracker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_o        (res)
  );

  // Result fields onto the output channel.
  assign out_o.kind       = res.kind;
  assign out_o.stream_sel = res.stream_sel;
  assign out_o.out_byte   = res.out_byte;
  assign out_o.unit_first = res.unit_first;
  assign out_o.ts_present = res.ts_present;
  assign out_o.pts_value  = res.pts_value;
  assign out_o.dts_value  = res.dts_value;

endmodule

`default_nettype wire

### hw/rtl/psd_checker.sv
// Port-level checks on the demultiplexer's result channel, bound to the top
// level. Depends on psd_pkg and program_stream_demultiplexer.
`default_nettype none

module psd_checker
  import psd_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        kind_i,
  input logic [7:0]  out_byte_i,
  input logic        unit_first_i,
  input logic        ts_present_i,
  input logic [32:0] pts_value_i,
  input logic [32:0] dts_value_i
);

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_byte_i) && $stable(pts_value_i))
    else $error("result changed while stalled");

  // A unit end carries no byte and no timestamps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == KIND_UNIT_END) |->
      (out_byte_i == 8'd0) && !unit_first_i && !ts_present_i &&
      (pts_value_i == '0) && (dts_value_i == '0))
    else $error("unit end with payload fields set");

  // Timestamps appear only on the first byte of a unit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !unit_first_i |->
      !ts_present_i && (pts_value_i == '0) && (dts_value_i == '0))
    else $error("timestamp on a byte that does not open a unit");

endmodule

bind program_stream_demultiplexer psd_checker u_psd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .kind_i       (out_o.kind),
  .out_byte_i   (out_o.out_byte),
  .unit_first_i (out_o.unit_first),
  .ts_present_i (out_o.ts_present),
  .pts_value_i  (out_o.pts_value),
  .dts_value_i  (out_o.dts_value)
);

`default_nettype wire

### verif/program_stream_demultiplexer_tb.sv
// Self-checking testbench for the program stream demultiplexer: it builds program streams,
// predicts payload bytes and access unit ends, and compares every result transaction.
// Depends on psd_pkg, the psd_in_if/psd_out_if interfaces and the demultiplexer RTL.
`default_nettype none

module program_stream_demultiplexer_tb;
  import psd_pkg::*;

  // Stream codes and PES flag patterns that the stimulus uses.
  localparam logic [7:0] SC_SYSTEM    = 8'hBB;
  localparam logic [7:0] SC_PADDING   = 8'hBE;
  localparam logic [7:0] SC_PRIVATE2  = 8'hBF;
  localparam logic [7:0] SC_AUDIO0    = 8'hC0;
  localparam logic [7:0] SC_VIDEO0    = 8'hE0;
  localparam logic [7:0] SC_VIDEO_MAX = 8'hEF;
  localparam logic [7:0] FL_NONE      = 8'h00;
  localparam logic [7:0] FL_PTS       = 8'h80;
  localparam logic [7:0] FL_PTS_DTS   = 8'hC0;
  localparam logic [7:0] FL_DTS_ONLY  = 8'h40;
  localparam logic [32:0] TS_MAX      = 33'h1_FFFF_FFFF;
  localparam int CYCLE_LIMIT          = 1_000_000;
  localparam int RANDOM_ITEMS         = 230;

  logic clk_i;
  logic rst_ni;

  psd_in_if  in_if ();
  psd_out_if out_if ();

  program_stream_demultiplexer dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Clock with a period of four time units.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Parser state of the predictor.
  psd_phase_e  ph;
  logic [23:0] win;
  logic [16:0] pos;
  logic [15:0] remaining;
  logic [7:0]  code;
  logic [7:0]  flags;
  logic [7:0]  hdr_left;
  logic [2:0]  drop_left;
  logic [32:0] pts_acc;
  logic [32:0] dts_acc;
  // Per elementary stream access unit state, indexed by the stream selector.
  logic [32:0] au_pts [2];
  logic [32:0] au_dts [2];
  bit          au_ts [2];
  bit          au_open [2];
  bit          au_data [2];

  psd_result_t results_due [$];
  logic [7:0]  pending_bytes [$];
  int          mismatch_count;
  int          items_sent;
  int          cycle_count;
  int          sink_hold;
  bit          idle_on;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Closes a unit; an end is due only when the unit carried payload.
  function void close_unit(bit s);
    psd_result_t r;
    if (au_open[s] && au_data[s]) begin
      r = '0;
      r.kind = KIND_UNIT_END;
      r.stream_sel = s;
      results_due = {results_due, r};
    end
    au_open[s] = 1'b0;
    au_data[s] = 1'b0;
    au_ts[s]   = 1'b0;
    au_pts[s]  = '0;
    au_dts[s]  = '0;
  endfunction

  function void restart_search();
    ph  = PH_SEARCH;
    win = '0;
    pos = '0;
  endfunction

  function bit video_code();
    return code[7:4] == SC_VIDEO_NIB;
  endfunction

  // Audio payload loses a four byte sub-header when there is room for it.
  function void start_payload();
    if (remaining == 0) begin
      restart_search();
    end else begin
      ph = PH_PAYLOAD;
      drop_left = (code == SC_PRIVATE1 && remaining >= 4) ? 3'd4 : 3'd0;
    end
  endfunction

  function void reset_demux_state();
    restart_search();
    remaining = '0;
    code      = '0;
    flags     = '0;
    hdr_left  = '0;
    drop_left = '0;
    pts_acc   = '0;
    dts_acc   = '0;
    au_open[0] = 1'b0;
    au_open[1] = 1'b0;
    au_data[0] = 1'b0;
    au_data[1] = 1'b0;
    au_ts[0]   = 1'b0;
    au_ts[1]   = 1'b0;
    au_pts[0]  = '0;
    au_pts[1]  = '0;
    au_dts[0]  = '0;
    au_dts[1]  = '0;
  endfunction

  // Advances the parser by one accepted transaction and queues what it yields.
  function void demux_byte(logic op_f, logic [7:0] b);
    bit          s;
    int          i;
    int          full;
    psd_result_t r;
    s = video_code() ? SEL_VIDEO : SEL_AUDIO;
    if (op_f == OP_FLUSH) begin
      close_unit(SEL_VIDEO);
      close_unit(SEL_AUDIO);
      return;
    end
    case (ph)
      PH_ID: begin
        code = b;
        if (b == SC_PACK) begin
          pos = 17'd4;
          ph  = PH_PACK;
        end else if (b == SC_END) begin
          restart_search();
        end else begin
          ph = PH_LEN_HI;
        end
      end
      PH_PACK: begin
        if (pos >= 13) begin
          drop_left = b[2:0] & PACK_STUFF_MSK;
          if (drop_left == 0) restart_search();
          else ph = PH_STUFF;
        end else begin
          pos++;
        end
      end
      PH_STUFF: begin
        drop_left--;
        if (drop_left == 0) restart_search();
      end
      PH_LEN_HI: begin
        remaining = {b, 8'h00};
        ph = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        remaining[7:0] = b;
        if ((video_code() || code == SC_PRIVATE1) && remaining >= 3) ph = PH_FLAG1;
        else if (remaining == 0) restart_search();
        else ph = PH_SKIP;
      end
      PH_SKIP: begin
        remaining--;
        if (remaining == 0) restart_search();
      end
      PH_FLAG1: begin
        remaining--;
        ph = PH_FLAG2;
      end
      PH_FLAG2: begin
        flags = b;
        remaining--;
        ph = PH_HLEN;
      end
      PH_HLEN: begin
        remaining--;
        hdr_left = b;
        // A header longer than the packet marks it as malformed.
        if (b > remaining) begin
          if (remaining == 0) restart_search();
          else ph = PH_SKIP;
        end else begin
          if (flags[PTS_FLAG_BIT]) close_unit(s);
          au_open[s] = 1'b1;
          pos     = '0;
          pts_acc = '0;
          dts_acc = '0;
          if (hdr_left == 0) start_payload();
          else ph = PH_HEADER;
        end
      end
      PH_HEADER: begin
        i    = pos;
        full = i + hdr_left;
        remaining--;
        hdr_left--;
        pos++;
        // The PTS occupies the first five header bytes.
        if (flags[PTS_FLAG_BIT] && full >= 5 && i < 5) begin
          case (i)
            0: pts_acc = {b[3:1], 30'd0};
            1: pts_acc[29:22] = b;
            2: pts_acc[21:15] = b[7:1];
            3: pts_acc[14:7] = b;
            default: begin
              pts_acc[6:0] = b[7:1];
              au_open[s] = 1'b1;
              au_ts[s]   = 1'b1;
              au_pts[s]  = pts_acc;
              au_dts[s]  = pts_acc;
            end
          endcase
        end
        // The DTS follows in the next five bytes.
        if (flags[PTS_FLAG_BIT] && flags[DTS_FLAG_BIT] && full >= 10 && i >= 5 && i < 10) begin
          case (i)
            5: dts_acc = {b[3:1], 30'd0};
            6: dts_acc[29:22] = b;
            7: dts_acc[21:15] = b[7:1];
            8: dts_acc[14:7] = b;
            default: begin
              dts_acc[6:0] = b[7:1];
              au_open[s] = 1'b1;
              au_dts[s]  = dts_acc;
            end
          endcase
        end
        if (hdr_left == 0) start_payload();
      end
      PH_PAYLOAD: begin
        remaining--;
        if (drop_left > 0) begin
          drop_left--;
        end else begin
          r = '0;
          r.kind       = KIND_PAYLOAD;
          r.stream_sel = s;
          r.out_byte   = b;
          if (!au_data[s]) begin
            r.unit_first = 1'b1;
            r.ts_present = au_ts[s];
            r.pts_value  = au_pts[s];
            r.dts_value  = au_dts[s];
          end
          au_open[s] = 1'b1;
          au_data[s] = 1'b1;
          results_due = {results_due, r};
        end
        if (remaining == 0) restart_search();
      end
      default: begin
        // Start code search over the last three bytes.
        ph  = PH_SEARCH;
        win = {win[15:0], b};
        if (pos < 3) pos++;
        if (pos >= 3 && win == 24'h000001) begin
          ph  = PH_ID;
          win = '0;
          pos = '0;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: predicts on every input transaction, checks every result.
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [32:0] want, logic [32:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : scoreboard
    psd_result_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) demux_byte(in_if.op, in_if.in_byte);
      if (out_if.valid && out_if.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: result with none due, expected nothing, actual kind %0d sel %0d byte %0h",
                   $time, out_if.kind, out_if.stream_sel, out_if.out_byte);
          mismatch_count++;
        end else begin
          want = results_due.pop_front();
          check_field("kind", want.kind, out_if.kind);
          check_field("stream_sel", want.stream_sel, out_if.stream_sel);
          check_field("out_byte", want.out_byte, out_if.out_byte);
          check_field("unit_first", want.unit_first, out_if.unit_first);
          check_field("ts_present", want.ts_present, out_if.ts_present);
          check_field("pts_value", want.pts_value, out_if.pts_value);
          check_field("dts_value", want.dts_value, out_if.dts_value);
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Transaction drivers
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one.
  function automatic int idle_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin : result_sink
    int stall;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        stall = sink_hold;
        sink_hold = 0;
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Offers one transaction and waits until it is taken.
  task automatic send_item(logic op_f, logic [7:0] b);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.op      <= op_f;
    in_if.in_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_flush();
    send_item(OP_FLUSH, 8'($urandom_range(0, 255)));
  endtask

  // Sends the bytes built up so far, with a flush slipped in before one index.
  task automatic send_pending(int flush_at);
    foreach (pending_bytes[k]) begin
      if (k == flush_at) send_flush();
      send_item(OP_BYTE, pending_bytes[k]);
    end
    pending_bytes.delete();
  endtask

  // ---------------------------------------------------------------------------
  // Stream builders
  // ---------------------------------------------------------------------------

  // Appends one byte to the stream under construction.
  function void add_byte(logic [7:0] b);
    pending_bytes = {pending_bytes, b};
  endfunction

  function automatic logic [32:0] rand_ts();
    logic [32:0] t;
    t[31:0] = $urandom;
    t[32]   = 1'($urandom_range(0, 1));
    return t;
  endfunction

  // One of the five bytes of a coded timestamp; marker bits are random.
  function automatic logic [7:0] ts_byte(logic [32:0] t, int k);
    logic [7:0] f;
    f = 8'($urandom_range(0, 255));
    case (k)
      0: return {f[7:4], t[32:30], f[0]};
      1: return t[29:22];
      2: return {t[21:15], f[0]};
      3: return t[14:7];
      default: return {t[6:0], f[0]};
    endcase
  endfunction

  function void add_start(logic [7:0] sc);
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'h01);
    add_byte(sc);
  endfunction

  function void add_random(int n);
    repeat (n) add_byte(8'($urandom_range(0, 255)));
  endfunction

  function void add_len(int len);
    add_byte(len[15:8]);
    add_byte(len[7:0]);
  endfunction

  // Pack header: nine filler bytes, the stuffing count, then the stuffing.
  function void add_pack(int stuff);
    logic [7:0] b;
    add_start(SC_PACK);
    add_random(9);
    b = 8'($urandom_range(0, 255));
    b[2:0] = stuff[2:0];
    add_byte(b);
    add_random(stuff);
  endfunction

  function void add_other(logic [7:0] sc, int len);
    add_start(sc);
    add_len(len);
    add_random(len);
  endfunction

  // PES packet; len_delta moves the length field away from the true size.
  function void add_pes(logic [7:0] sc, logic [7:0] fl, int hlen, int paylen, int len_delta,
                        logic [32:0] pts_v, logic [32:0] dts_v);
    int len;
    len = 3 + hlen + paylen + len_delta;
    if (len < 0) len = 0;
    if (len > 65535) len = 65535;
    add_start(sc);
    add_len(len);
    add_byte(8'($urandom_range(128, 191)));
    add_byte(fl);
    add_byte(hlen[7:0]);
    for (int k = 0; k < hlen; k++) begin
      if (k < 5) add_byte(ts_byte(pts_v, k));
      else if (k < 10) add_byte(ts_byte(dts_v, k - 5));
      else add_byte(8'($urandom_range(0, 255)));
    end
    add_random(paylen);
  endfunction

  // PES packet whose header length points beyond the packet.
  function void add_bad_header(logic [7:0] sc, int len, int hlen);
    add_start(sc);
    add_len(len);
    add_byte(8'($urandom_range(128, 191)));
    add_byte(FL_PTS_DTS);
    add_byte(hlen[7:0]);
    add_random(len - 3);
  endfunction

  function void add_random_pes(logic [7:0] sc);
    logic [7:0] fl;
    int         pick;
    int         hlen;
    int         paylen;
    int         delta;
    fl = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 3);
    fl[7:6] = pick[1:0];
    pick = $urandom_range(0, 9);
    if (pick < 4) hlen = 5 + $urandom_range(0, 2);
    else if (pick < 7) hlen = 10 + $urandom_range(0, 3);
    else if (pick < 9) hlen = $urandom_range(0, 12);
    else hlen = $urandom_range(13, 40);
    paylen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    delta = ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 4)) - 2 : 0;
    add_pes(sc, fl, hlen, paylen, delta, rand_ts(), rand_ts());
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Start code search needs three real bytes; the window is emptied per packet.
  task automatic test_start_search();
    pending_bytes = {8'h00, 8'h01, SC_VIDEO0, 8'h00};
    add_other(SC_SYSTEM, 0);
    add_start(SC_END);
    add_byte(8'h00);
    add_byte(8'h01);
    add_byte(SC_VIDEO0);
    add_pes(SC_VIDEO0, FL_NONE, 0, 1, 0, '0, '0);
    send_pending(-1);
  endtask

  // Pack headers with no stuffing and with the most stuffing.
  task automatic test_pack_headers();
    add_pack(0);
    add_pack(7);
    add_pes(SC_VIDEO_MAX, FL_PTS, 5, 2, 0, TS_MAX, '0);
    send_pending(-1);
  endtask

  // Non-target packets are passed over by their length field.
  task automatic test_skipped_packets();
    add_other(SC_SYSTEM, 3);
    add_other(SC_PADDING, 2);
    add_other(SC_PRIVATE2, 1);
    add_other(SC_AUDIO0, 2);
    add_other(8'h00, 1);
    add_other(8'hFF, 0);
    add_start(SC_END);
    send_pending(-1);
  endtask

  // Timestamp extraction and unit closing on video.
  task automatic test_video_timestamps();
    add_pes(SC_VIDEO0, FL_PTS_DTS, 10, 2, 0, TS_MAX, '0);
    add_pes(SC_VIDEO0, FL_PTS, 5, 1, 0, '0, TS_MAX);
    add_pes(SC_VIDEO0, FL_PTS_DTS, 7, 1, 0, rand_ts(), rand_ts());
    add_pes(SC_VIDEO0, FL_PTS, 3, 1, 0, rand_ts(), rand_ts());
    add_pes(SC_VIDEO0, FL_DTS_ONLY, 10, 1, 0, rand_ts(), rand_ts());
    add_pes(SC_VIDEO0, FL_NONE, 12, 0, 0, rand_ts(), rand_ts());
    add_pes(SC_VIDEO0, FL_PTS, 5, 0, 0, rand_ts(), rand_ts());
    add_pes(SC_VIDEO0, FL_PTS_DTS, 10, 1, 0, rand_ts(), rand_ts());
    send_pending(-1);
  endtask

  // Private stream 1 drops a four byte sub-header only when it fits.
  task automatic test_audio_subheader();
    add_pes(SC_PRIVATE1, FL_PTS, 5, 6, 0, rand_ts(), rand_ts());
    add_pes(SC_PRIVATE1, FL_NONE, 0, 3, 0, '0, '0);
    add_pes(SC_PRIVATE1, FL_NONE, 0, 4, 0, '0, '0);
    add_pes(SC_PRIVATE1, FL_PTS_DTS, 10, 5, 0, TS_MAX, TS_MAX);
    send_pending(-1);
    send_flush();
  endtask

  // Short packets and oversized headers close nothing.
  task automatic test_malformed();
    add_pes(SC_VIDEO0, FL_NONE, 0, 2, 0, '0, '0);
    add_other(SC_VIDEO0, 2);
    add_other(SC_PRIVATE1, 0);
    add_bad_header(SC_VIDEO0, 5, 3);
    add_bad_header(SC_PRIVATE1, 3, 1);
    add_bad_header(SC_VIDEO0, 6, 255);
    add_pes(SC_VIDEO0, FL_NONE, 0, 1, 0, '0, '0);
    send_pending(-1);
  endtask

  // Flush with nothing open, with both units open, and inside a packet.
  task automatic test_flush();
    send_flush();
    send_flush();
    add_pes(SC_VIDEO0, FL_PTS, 5, 2, 0, rand_ts(), rand_ts());
    add_pes(SC_PRIVATE1, FL_PTS, 5, 5, 0, rand_ts(), rand_ts());
    send_pending(-1);
    send_flush();
    // Flush among the timestamp bytes; the second packet's flush index lies beyond its bytes.
    add_pes(SC_VIDEO0, FL_PTS_DTS, 10, 4, 0, rand_ts(), rand_ts());
    send_pending(12);
    add_pes(SC_VIDEO0, FL_PTS, 5, 4, 0, rand_ts(), rand_ts());
    send_pending(20);
    send_flush();
  endtask

  // Mostly well-formed packets with random content, some noise and breakage.
  task automatic test_random_stream(int count);
    int stop;
    int pick;
    int flush_at;
    stop = items_sent + count;
    while (items_sent < stop) begin
      idle_on = ((items_sent / 150) % 3) != 2;
      pick = $urandom_range(0, 99);
      if (pick < 36) begin
        add_random_pes(SC_VIDEO0 | 8'($urandom_range(0, 15)));
      end else if (pick < 58) begin
        add_random_pes(SC_PRIVATE1);
      end else if (pick < 66) begin
        add_pack($urandom_range(0, 7));
      end else if (pick < 72) begin
        add_other(8'($urandom_range(0, 255)), $urandom_range(0, 12));
      end else if (pick < 75) begin
        add_start(SC_END);
      end else if (pick < 81) begin
        if ($urandom_range(0, 1) == 0) add_other(SC_PRIVATE1, $urandom_range(0, 2));
        else add_bad_header(SC_VIDEO0, $urandom_range(3, 8), $urandom_range(6, 255));
      end else if (pick < 90) begin
        if ($urandom_range(0, 2) == 0) begin
          add_byte(8'h00);
          add_byte(8'h00);
        end
        add_random($urandom_range(1, 6));
      end else begin
        send_flush();
      end
      flush_at = -1;
      if ($urandom_range(0, 11) == 0) flush_at = $urandom_range(0, pending_bytes.size());
      send_pending(flush_at);
    end
    idle_on = 1'b1;
  endtask

  // The result side holds off for a long stretch while bytes keep coming.
  task automatic test_backpressure();
    idle_on = 1'b0;
    sink_hold = 300;
    add_pes(SC_VIDEO0, FL_PTS, 5, 40, 0, rand_ts(), rand_ts());
    add_pes(SC_PRIVATE1, FL_PTS_DTS, 10, 40, 0, rand_ts(), rand_ts());
    send_pending(-1);
    idle_on = 1'b1;
  endtask

  // A packet cut short by the end of the stream still forwards its bytes.
  task automatic test_truncated_tail();
    add_pes(SC_VIDEO0, FL_PTS, 5, 6, 70000, rand_ts(), rand_ts());
    send_pending(-1);
    send_flush();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    reset_demux_state();
    mismatch_count = 0;
    items_sent     = 0;
    cycle_count    = 0;
    sink_hold      = 0;
    idle_on        = 1'b1;
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.op      <= OP_BYTE;
    in_if.in_byte <= 8'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_start_search();
    test_pack_headers();
    test_skipped_packets();
    test_video_timestamps();
    test_audio_subheader();
    test_malformed();
    test_flush();
    test_random_stream(RANDOM_ITEMS);
    test_backpressure();
    test_truncated_tail();

    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire
